// ===== rtl/rtss_pkg.sv =====
// ----------------------------------------------------------------------------
// rtss_pkg
// Shared types and constants of the record table: request and status codes,
// controller states, the stored record and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rtss_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ID_W         = 31;
    localparam int YEAR_W       = 16;
    localparam int POS_W        = 7;
    localparam int CNT_OUT_W    = 7;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_SORT   = 2'd2,
        REQ_LIST   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH,
        S_FOUND,
        S_SORT_FILL,
        S_SORT_STEP,
        S_SORT_END,
        S_LIST,
        S_EMIT
    } state_t;

    // read address select
    typedef enum logic [1:0] {
        RSEL_ZERO,
        RSEL_IDX,
        RSEL_IDX1,
        RSEL_IDX2
    } rsel_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [YEAR_W-1:0] year;
    } rec_t;

    typedef struct packed {
        logic    latch_in;
        logic    idx_clr;
        logic    idx_inc;
        rsel_t   rsel;
        logic    wr_append;
        logic    wr_sort;
        logic    wr_end;
        logic    carry_load;
        logic    lim_init;
        logic    lim_dec;
        logic    st_load;
        status_t st_val;
        logic    out_rec;
        logic    rec_last;
        logic    out_stat;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic cnt_zero;
        logic cnt_lt2;
        logic cnt_full;
        logic hit;
        logic idx_at_end;
        logic step_end;
        logic lim_last;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/rtss_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtss_ctrl
// Request sequencer: dispatches append, search, sort and list, and steps the
// datapath through table walks and bubble sort passes.
// ----------------------------------------------------------------------------
module rtss_ctrl
    import rtss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.req)
                    REQ_APPEND: state_next = S_EMIT;
                    REQ_SEARCH: state_next = sts.cnt_zero ? S_EMIT : S_SRCH;
                    REQ_SORT:   state_next = sts.cnt_lt2 ? S_EMIT : S_SORT_FILL;
                    REQ_LIST:   state_next = sts.cnt_zero ? S_EMIT : S_LIST;
                    default:    state_next = S_EMIT;
                endcase
            end
            S_SRCH:
            begin
                if (sts.hit)
                begin
                    state_next = S_FOUND;
                end
                else if (sts.idx_at_end)
                begin
                    state_next = S_EMIT;
                end
            end
            S_FOUND:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SORT_FILL:
            begin
                state_next = S_SORT_STEP;
            end
            S_SORT_STEP:
            begin
                if (sts.step_end)
                begin
                    state_next = S_SORT_END;
                end
            end
            S_SORT_END:
            begin
                state_next = sts.lim_last ? S_EMIT : S_SORT_FILL;
            end
            S_LIST:
            begin
                if (sts.out_free && sts.idx_at_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.rsel = RSEL_IDX;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    cmd.idx_clr  = 1'b1;
                end
            end
            S_DISPATCH:
            begin
                case (sts.req)
                    REQ_APPEND:
                    begin
                        cmd.st_load = 1'b1;
                        if (sts.cnt_full)
                        begin
                            cmd.st_val = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_append = 1'b1;
                            cmd.st_val    = ST_OK;
                        end
                    end
                    REQ_SEARCH:
                    begin
                        if (sts.cnt_zero)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_val  = ST_NOT_FOUND;
                        end
                    end
                    REQ_SORT:
                    begin
                        if (sts.cnt_lt2)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_val  = ST_OK;
                        end
                        else
                        begin
                            cmd.lim_init = 1'b1;
                        end
                    end
                    REQ_LIST:
                    begin
                        if (sts.cnt_zero)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_val  = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        cmd.st_load = 1'b1;
                        cmd.st_val  = ST_OK;
                    end
                endcase
            end
            S_SRCH:
            begin
                if (!sts.hit)
                begin
                    if (sts.idx_at_end)
                    begin
                        cmd.st_load = 1'b1;
                        cmd.st_val  = ST_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        cmd.rsel    = RSEL_IDX1;
                    end
                end
            end
            S_FOUND:
            begin
                // hold the read address so the hit record stays in the read register
                if (sts.out_free)
                begin
                    cmd.out_rec  = 1'b1;
                    cmd.rec_last = 1'b1;
                end
            end
            S_SORT_FILL:
            begin
                cmd.carry_load = 1'b1;
                cmd.rsel       = RSEL_IDX1;
            end
            S_SORT_STEP:
            begin
                cmd.wr_sort = 1'b1;
                cmd.rsel    = RSEL_IDX2;
                if (!sts.step_end)
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SORT_END:
            begin
                cmd.wr_end  = 1'b1;
                cmd.lim_dec = 1'b1;
                cmd.idx_clr = 1'b1;
                cmd.rsel    = RSEL_ZERO;
                if (sts.lim_last)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_val  = ST_OK;
                end
            end
            S_LIST:
            begin
                if (sts.out_free)
                begin
                    cmd.out_rec  = 1'b1;
                    cmd.rec_last = sts.idx_at_end;
                    cmd.rsel     = RSEL_IDX1;
                    if (!sts.idx_at_end)
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_stat = 1'b1;
                end
            end
            default:
            begin
                cmd.rsel = RSEL_IDX;
            end
        endcase
    end

    a_out_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_rec || cmd.out_stat) |-> sts.out_free)
        else $error("result loaded while output register is occupied");

    a_final_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.out_rec && cmd.rec_last) || cmd.out_stat) |=> state_reg == S_IDLE)
        else $error("final result not followed by return to idle");

    a_one_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.wr_append, cmd.wr_sort, cmd.wr_end}) <= 1)
        else $error("more than one table write source in a cycle");

endmodule

// ===== rtl/rtss_datapath.sv =====
// ----------------------------------------------------------------------------
// rtss_datapath
// Record memory with one write and one registered read port, count, walk
// index, sort pass limit and carry record, and the output register.
// ----------------------------------------------------------------------------
module rtss_datapath
    import rtss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [1:0]           req_type,
    input  logic [ID_W-1:0]      student_id,
    input  logic [YEAR_W-1:0]    entry_year,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [POS_W-1:0]     position,
    output logic [ID_W-1:0]      found_id,
    output logic [YEAR_W-1:0]    found_year,
    output logic [CNT_OUT_W-1:0] record_count,
    output logic                 last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    rec_t mem [CAPACITY];
    rec_t rdata_reg;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    rec_t wdata;
    logic wen;

    req_t              req_reg;
    logic [ID_W-1:0]   key_reg;
    logic [YEAR_W-1:0] year_reg;
    status_t           st_reg;
    rec_t              carry_reg;

    logic [AW-1:0] idx_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] lim_reg;
    logic          keep_carry;

    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [POS_W-1:0]     out_pos_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [YEAR_W-1:0]    out_year_reg;
    logic [CNT_OUT_W-1:0] out_cnt_reg;
    logic                 out_last_reg;

    // carry holds the larger year; ties move the carry down to keep order
    assign keep_carry = carry_reg.year > rdata_reg.year;

    always_comb
    begin
        case (cmd.rsel)
            RSEL_ZERO: raddr = '0;
            RSEL_IDX:  raddr = idx_reg;
            RSEL_IDX1: raddr = idx_reg + AW'(1);
            RSEL_IDX2: raddr = idx_reg + AW'(2);
            default:   raddr = idx_reg;
        endcase
    end

    always_comb
    begin
        wen = cmd.wr_append || cmd.wr_sort || cmd.wr_end;
        if (cmd.wr_append)
        begin
            waddr = AW'(count_reg);
            wdata = '{id: key_reg, year: year_reg};
        end
        else if (cmd.wr_sort)
        begin
            waddr = idx_reg;
            wdata = keep_carry ? rdata_reg : carry_reg;
        end
        else
        begin
            waddr = AW'(lim_reg - CW'(1));
            wdata = carry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            req_reg  <= req_t'(req_type);
            key_reg  <= student_id;
            year_reg <= entry_year;
        end
        if (cmd.st_load)
        begin
            st_reg <= cmd.st_val;
        end
        if (cmd.carry_load)
        begin
            carry_reg <= rdata_reg;
        end
        else if (cmd.wr_sort && !keep_carry)
        begin
            carry_reg <= rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
            lim_reg   <= '0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (cmd.wr_append)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.lim_init)
            begin
                lim_reg <= count_reg;
            end
            else if (cmd.lim_dec)
            begin
                lim_reg <= lim_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_rec || cmd.out_stat)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_rec)
        begin
            out_status_reg <= ST_OK;
            out_pos_reg    <= POS_W'(idx_reg) + POS_W'(1);
            out_id_reg     <= rdata_reg.id;
            out_year_reg   <= rdata_reg.year;
            out_cnt_reg    <= CNT_OUT_W'(count_reg);
            out_last_reg   <= cmd.rec_last;
        end
        else if (cmd.out_stat)
        begin
            out_status_reg <= st_reg;
            out_pos_reg    <= '0;
            out_id_reg     <= '0;
            out_year_reg   <= '0;
            out_cnt_reg    <= CNT_OUT_W'(count_reg);
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign position     = out_pos_reg;
    assign found_id     = out_id_reg;
    assign found_year   = out_year_reg;
    assign record_count = out_cnt_reg;
    assign last         = out_last_reg;

    always_comb
    begin
        sts.req        = req_reg;
        sts.cnt_zero   = count_reg == '0;
        sts.cnt_lt2    = count_reg < CW'(2);
        sts.cnt_full   = count_reg == CW'(CAPACITY);
        sts.hit        = rdata_reg.id == key_reg;
        sts.idx_at_end = (CW'(idx_reg) + CW'(1)) == count_reg;
        sts.step_end   = (CW'(idx_reg) + CW'(2)) == lim_reg;
        sts.lim_last   = lim_reg == CW'(2);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("record count above capacity");

    a_append_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_append |-> !sts.cnt_full)
        else $error("append write into a full table");

    a_sort_step_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_sort |-> (CW'(idx_reg) + CW'(2)) <= lim_reg)
        else $error("sort step beyond the current pass");

endmodule

// ===== rtl/record_table_search_sort.sv =====
// ----------------------------------------------------------------------------
// record_table_search_sort
// Append writes the new record at the count; search reads the records in order until a hit.
// Sort runs bubble sort passes over n >= 2 records, one
// compare and write per cycle through the record memory's read and write port.
// List gives one record per cycle when the consumer takes each result.
// One item at a time; the next is taken once the final result is registered.
// Reset clears the count, index, pass limit and output valid; the memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module record_table_search_sort
    import rtss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [ID_W-1:0]      student_id,
    input  logic [YEAR_W-1:0]    entry_year,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [POS_W-1:0]     position,
    output logic [ID_W-1:0]      found_id,
    output logic [YEAR_W-1:0]    found_year,
    output logic [CNT_OUT_W-1:0] record_count,
    output logic                 last
);

    cmd_t cmd;
    sts_t sts;

    rtss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rtss_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .student_id   (student_id),
        .entry_year   (entry_year),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .position     (position),
        .found_id     (found_id),
        .found_year   (found_year),
        .record_count (record_count),
        .last         (last)
    );

endmodule
